// File: design/fpa_pkg.sv
// shared types and constants for the fixed-point alu pipeline
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

    // operation codes carried in tuser
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_LT   = 4'd4;
    localparam logic [3:0] OP_GT   = 4'd5;
    localparam logic [3:0] OP_LE   = 4'd6;
    localparam logic [3:0] OP_GE   = 4'd7;
    localparam logic [3:0] OP_NE   = 4'd8;
    localparam logic [3:0] OP_EQ   = 4'd9;
    localparam logic [3:0] OP_INC  = 4'd10;
    localparam logic [3:0] OP_DEC  = 4'd11;
    localparam logic [3:0] OP_MIN  = 4'd12;
    localparam logic [3:0] OP_MAX  = 4'd13;
    localparam logic [3:0] OP_FINT = 4'd14;
    localparam logic [3:0] OP_TINT = 4'd15;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] WORD_MIN = 32'sh80000000;

    // quotient bits resolved by the divider, one per stage
    localparam int DIV_STEPS = 33;

    // payload that travels down the pipeline
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] res;     // finished result of the operations done in the first stage
        logic        truth;
        logic [1:0]  status;
        logic        neg;     // sign of a product or quotient
        logic        dz;      // divisor is zero
        logic        ovf;     // quotient magnitude at least 2^33
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [63:0] prod;
        logic [31:0] rem;
        logic [32:0] quot;    // low dividend bits shift out, quotient bits shift in
    } pipe_t;

endpackage

`default_nettype wire

// File: design/fpa_front.sv
// first stage: decode, the operations that finish here, operand magnitudes
// and divider set-up; depends on fpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpa_front #(
    parameter int FRACTION_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         in_kind,
    input  logic signed [31:0] in_a,
    input  logic signed [31:0] in_b,
    output logic               out_valid,
    input  logic               out_ready,
    output fpa_pkg::pipe_t     out_data
);

    logic signed [32:0] sum;
    logic signed [32:0] diff;
    logic signed [31:0] hi;
    logic [64:0]        num;
    logic               valid_reg;
    fpa_pkg::pipe_t     data_reg;
    fpa_pkg::pipe_t     data_next;

    assign sum  = {in_a[31], in_a} + {in_b[31], in_b};
    assign diff = {in_a[31], in_a} - {in_b[31], in_b};
    // bits that a shift into fixed point would lose
    assign hi   = in_a >>> (31 - FRACTION_BITS);

    always_comb begin
        data_next        = '0;
        data_next.kind   = in_kind;
        data_next.status = fpa_pkg::ST_OK;
        data_next.neg    = in_a[31] ^ in_b[31];
        data_next.mag_a  = in_a[31] ? (~in_a + 32'd1) : in_a;
        data_next.mag_b  = in_b[31] ? (~in_b + 32'd1) : in_b;
        data_next.dz     = (in_b == 32'sd0);
        num              = {33'd0, data_next.mag_a} << FRACTION_BITS;
        data_next.ovf    = (num[64:33] >= data_next.mag_b);
        data_next.rem    = num[64:33];
        data_next.quot   = num[32:0];
        case (in_kind)
            fpa_pkg::OP_ADD: begin
                if (sum[32] != sum[31]) begin
                    data_next.res    = sum[32] ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
                    data_next.status = fpa_pkg::ST_SAT;
                end else begin
                    data_next.res = sum[31:0];
                end
            end
            fpa_pkg::OP_SUB: begin
                if (diff[32] != diff[31]) begin
                    data_next.res    = diff[32] ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
                    data_next.status = fpa_pkg::ST_SAT;
                end else begin
                    data_next.res = diff[31:0];
                end
            end
            fpa_pkg::OP_LT:  data_next.truth = (in_a < in_b);
            fpa_pkg::OP_GT:  data_next.truth = (in_a > in_b);
            fpa_pkg::OP_LE:  data_next.truth = (in_a <= in_b);
            fpa_pkg::OP_GE:  data_next.truth = (in_a >= in_b);
            fpa_pkg::OP_NE:  data_next.truth = (in_a != in_b);
            fpa_pkg::OP_EQ:  data_next.truth = (in_a == in_b);
            fpa_pkg::OP_INC: begin
                if (in_a == fpa_pkg::WORD_MAX) begin
                    data_next.res    = fpa_pkg::WORD_MAX;
                    data_next.status = fpa_pkg::ST_SAT;
                end else begin
                    data_next.res = in_a + 32'sd1;
                end
            end
            fpa_pkg::OP_DEC: begin
                if (in_a == fpa_pkg::WORD_MIN) begin
                    data_next.res    = fpa_pkg::WORD_MIN;
                    data_next.status = fpa_pkg::ST_SAT;
                end else begin
                    data_next.res = in_a - 32'sd1;
                end
            end
            fpa_pkg::OP_MIN: data_next.res = (in_a < in_b) ? in_a : in_b;
            fpa_pkg::OP_MAX: data_next.res = (in_a > in_b) ? in_a : in_b;
            fpa_pkg::OP_FINT: begin
                if (hi == 32'sd0 || hi == -32'sd1) begin
                    data_next.res = in_a <<< FRACTION_BITS;
                end else begin
                    data_next.res    = in_a[31] ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
                    data_next.status = fpa_pkg::ST_SAT;
                end
            end
            fpa_pkg::OP_TINT: data_next.res = in_a >>> FRACTION_BITS;
            default: data_next.res = '0;    // multiply and divide finish at the back
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: design/fpa_mul.sv
// multiplier stage: unsigned 32x32 product of the operand magnitudes
// depends on fpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpa_mul (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  fpa_pkg::pipe_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output fpa_pkg::pipe_t out_data
);

    logic           valid_reg;
    fpa_pkg::pipe_t data_reg;
    fpa_pkg::pipe_t data_next;

    always_comb begin
        data_next      = in_data;
        data_next.prod = in_data.mag_a * in_data.mag_b;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: design/fpa_div_step.sv
// one restoring division step: resolves one quotient bit per stage
// depends on fpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpa_div_step (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  fpa_pkg::pipe_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output fpa_pkg::pipe_t out_data
);

    logic [32:0]    trial;
    logic           fits;
    logic           valid_reg;
    fpa_pkg::pipe_t data_reg;
    fpa_pkg::pipe_t data_next;

    // bring down the next dividend bit and try the divisor against it
    assign trial = {in_data.rem, in_data.quot[32]};
    assign fits  = (trial >= {1'b0, in_data.mag_b});

    always_comb begin
        data_next      = in_data;
        data_next.rem  = fits ? 32'(trial - {1'b0, in_data.mag_b}) : trial[31:0];
        data_next.quot = {in_data.quot[31:0], fits};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: design/fpa_back.sv
// last stage: rounding of product and quotient, sign, saturation,
// result selection and the output register; depends on fpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpa_back #(
    parameter int FRACTION_BITS = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  fpa_pkg::pipe_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    out_result,
    output logic           out_truth,
    output logic [1:0]     out_status
);

    logic [63:0] prod_rnd;
    logic        round_up;
    logic [33:0] quot_rnd;
    logic [63:0] mag;
    logic        big;
    logic        use_mag;
    logic [31:0] result_next;
    logic [1:0]  status_next;
    logic        valid_reg;
    logic [31:0] result_reg;
    logic        truth_reg;
    logic [1:0]  status_reg;

    // half an lsb added to the magnitude gives ties away from zero
    assign prod_rnd = (in_data.prod + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    assign round_up = ({in_data.rem, 1'b0} >= {1'b0, in_data.mag_b});
    assign quot_rnd = {1'b0, in_data.quot} + {33'd0, round_up};

    always_comb begin
        mag         = '0;
        big         = 1'b0;
        use_mag     = 1'b0;
        result_next = in_data.res;
        status_next = in_data.status;
        case (in_data.kind)
            fpa_pkg::OP_MUL: begin
                mag     = prod_rnd;
                use_mag = 1'b1;
            end
            fpa_pkg::OP_DIV: begin
                if (in_data.dz) begin
                    result_next = '0;
                    status_next = fpa_pkg::ST_DIVZ;
                end else begin
                    mag     = {30'd0, quot_rnd};
                    big     = in_data.ovf;
                    use_mag = 1'b1;
                end
            end
            default: ;
        endcase
        if (use_mag) begin
            status_next = fpa_pkg::ST_OK;
            if (in_data.neg) begin
                if (big || mag > 64'h8000_0000) begin
                    result_next = fpa_pkg::WORD_MIN;
                    status_next = fpa_pkg::ST_SAT;
                end else begin
                    result_next = ~mag[31:0] + 32'd1;
                end
            end else begin
                if (big || mag > 64'h7fff_ffff) begin
                    result_next = fpa_pkg::WORD_MAX;
                    status_next = fpa_pkg::ST_SAT;
                end else begin
                    result_next = mag[31:0];
                end
            end
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;
    assign out_truth  = truth_reg;
    assign out_status = status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            result_reg <= result_next;
            truth_reg  <= in_data.truth;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

// File: design/fixed_point_alu_top.sv
// Signed 32-bit fixed-point alu with FRACTION_BITS fractional bits. Takes one
// beat per cycle unless stalled by back-pressure and returns one result beat
// per input beat, in order, through one decode stage, one multiplier stage, 33
// restoring division stages (one quotient bit each) and the output register. All
// operations share the same pipeline, so the divider chain sets the latency.
// Each stage holds its beat under back-pressure and keeps filling bubbles.
// depends on fpa_pkg, fpa_front, fpa_mul, fpa_div_step, fpa_back
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_alu_top #(
    parameter int FRACTION_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
    input  logic [3:0]  s_tuser,   // kind [3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // result [31:0], truth [32], status [34:33], zero
);

    logic           front_valid;
    logic           front_ready;
    fpa_pkg::pipe_t front_data;
    logic           div_valid [0:fpa_pkg::DIV_STEPS];
    logic           div_ready [0:fpa_pkg::DIV_STEPS];
    fpa_pkg::pipe_t div_data  [0:fpa_pkg::DIV_STEPS];
    logic [31:0]    result;
    logic           truth;
    logic [1:0]     status;

    fpa_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_a      (s_tdata[31:0]),
        .in_b      (s_tdata[63:32]),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    fpa_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    for (genvar i = 0; i < fpa_pkg::DIV_STEPS; i++) begin : g_div
        fpa_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[i]),
            .in_ready  (div_ready[i]),
            .in_data   (div_data[i]),
            .out_valid (div_valid[i+1]),
            .out_ready (div_ready[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    fpa_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (div_valid[fpa_pkg::DIV_STEPS]),
        .in_ready   (div_ready[fpa_pkg::DIV_STEPS]),
        .in_data    (div_data[fpa_pkg::DIV_STEPS]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result),
        .out_truth  (truth),
        .out_status (status)
    );

    assign m_tdata = {5'd0, status, truth, result};

    // the input side only stalls when every stage, the output included, is full
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with a free output register");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[34:33] != 2'd3))
        else $error("status code out of range");

    // a true comparison outcome comes with a zero result and ok status
    a_truth_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[32]) |-> (m_tdata[31:0] == 32'd0 &&
                                       m_tdata[34:33] == fpa_pkg::ST_OK))
        else $error("comparison beat with non-zero result or status");

    a_divz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[34:33] == fpa_pkg::ST_DIVZ) |-> (m_tdata[31:0] == 32'd0))
        else $error("division by zero with non-zero result");

    // a saturated result sits on one of the two range limits
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[34:33] == fpa_pkg::ST_SAT) |->
            (m_tdata[31:0] == 32'h7fff_ffff || m_tdata[31:0] == 32'h8000_0000))
        else $error("saturated result off the range limits");

endmodule

`default_nettype wire
